// ----- hdl/idq_pkg.sv -----
package idq_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int FIDX_W  = 5;
   localparam int DATA_W  = 32;

   typedef enum logic [3:0] {
      OP_ADD_FRONT  = 4'd0,
      OP_ADD_BACK   = 4'd1,
      OP_TAKE_FRONT = 4'd2,
      OP_TAKE_BACK  = 4'd3,
      OP_READ       = 4'd4,
      OP_REPLACE    = 4'd5,
      OP_INSERT     = 4'd6,
      OP_REMOVE     = 4'd7,
      OP_REMOVE_ALL = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_WRITE,
      ACT_SHIFT_UP,
      ACT_SHIFT_DOWN
   } act_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

   // broadcast to every cell of the row
   typedef struct packed {
      act_type                    act;
      logic [IDX_W-1:0]           pos;
      logic signed [DATA_W-1:0]   value;
   } cell_ctrl_type;

endpackage

// ----- hdl/idq_cell.sv -----
module idq_cell
   import idq_pkg::*;
(
   input  logic                       clock,
   input  cell_ctrl_type              ctrl,
   input  logic [IDX_W-1:0]           my_pos,
   input  logic signed [DATA_W-1:0]   prev_data,
   input  logic signed [DATA_W-1:0]   next_data,
   output logic signed [DATA_W-1:0]   data
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.act)
         ACT_WRITE: begin
            if (my_pos == ctrl.pos) data_in = ctrl.value;
         end
         ACT_SHIFT_UP: begin
            // entries at and above pos move one place towards the back
            if (my_pos == ctrl.pos)     data_in = ctrl.value;
            else if (my_pos > ctrl.pos) data_in = prev_data;
         end
         ACT_SHIFT_DOWN: begin
            // entry at pos is dropped, later ones close the gap
            if (my_pos >= ctrl.pos) data_in = next_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- hdl/indexed_double_ended_queue_top.sv -----
// Indexed double-ended queue of up to 16 signed 32-bit entries.
// Request channel (req_valid/req_ready): one command per transaction, with
// req_opcode, req_data_in and req_index. Response channel (rsp_valid/rsp_ready):
// exactly one transaction per command carrying data_out, removed_count,
// count_after and status.
// Entries sit in logical order in a row of cells; entry 0 is cell 0. Push
// front, insert, pop front and remove move every later cell by one place
// together, each cell taking its neighbour's value.
// Timing: a command is taken in ST_IDLE and executed in the next cycle if the
// output register is free; the response is registered. Remove all then walks
// the row in ST_SCAN, each step either dropping a match at the scan position or
// moving on, and responds once the scan passes the end of the list.
// One command is in flight at a time.
// The response sits in an output register; if the receiver stalls, the next
// command is still accepted but its execution waits until that register is
// free, and no state changes until then.
// Reset (synchronous, active high) empties the list and drops any pending
// command or response; cell contents are not cleared and are never read
// before being written.
module indexed_double_ended_queue_top
   import idq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [3:0]                 req_opcode,
   input  logic signed [DATA_W-1:0]   req_data_in,
   input  logic [FIDX_W-1:0]          req_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DATA_W-1:0]   rsp_data_out,
   output logic [CNT_W-1:0]           rsp_removed_count,
   output logic [CNT_W-1:0]           rsp_count_after,
   output logic [1:0]                 rsp_status
);

   state_type                  state_ff, state_in;
   op_type                     cmd_op_ff, cmd_op_in;
   logic signed [DATA_W-1:0]   cmd_data_ff, cmd_data_in;
   logic [FIDX_W-1:0]          cmd_index_ff, cmd_index_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           scan_pos_ff, scan_pos_in;
   logic [CNT_W-1:0]           removed_ff, removed_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]           rsp_removed_ff, rsp_removed_in;
   logic [CNT_W-1:0]           rsp_count_ff, rsp_count_in;
   status_type                 rsp_status_ff, rsp_status_in;

   cell_ctrl_type              ctrl;
   logic signed [DATA_W-1:0]   cell_data [DEPTH];

   logic out_free;
   logic req_fire;
   logic emit;
   logic full;
   logic empty;
   logic scan_done;
   logic scan_match;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign scan_done = (scan_pos_ff >= count_ff);
   assign scan_match = (cell_data[scan_pos_ff[IDX_W-1:0]] == cmd_data_ff);

   // ---- cell row ----
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [DATA_W-1:0] prev_d;
      logic signed [DATA_W-1:0] next_d;
      if (g == 0) begin : g_first
         assign prev_d = '0;
      end else begin : g_mid_lo
         assign prev_d = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign next_d = '0;
      end else begin : g_mid_hi
         assign next_d = cell_data[g+1];
      end
      idq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .my_pos    (IDX_W'(g)),
         .prev_data (prev_d),
         .next_data (next_d),
         .data      (cell_data[g])
      );
   end

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = (cmd_op_ff == OP_REMOVE_ALL) ? ST_SCAN : ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_done && out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---- command execution and response ----
   always_comb begin
      cmd_op_in      = cmd_op_ff;
      cmd_data_in    = cmd_data_ff;
      cmd_index_in   = cmd_index_ff;
      count_in       = count_ff;
      scan_pos_in    = scan_pos_ff;
      removed_in     = removed_ff;
      ctrl.act       = ACT_NONE;
      ctrl.pos       = '0;
      ctrl.value     = cmd_data_ff;
      emit           = 1'b0;
      rsp_data_in    = '0;
      rsp_removed_in = '0;
      rsp_status_in  = STAT_OK;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_op_in    = op_type'(req_opcode);
               cmd_data_in  = req_data_in;
               cmd_index_in = req_index;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               emit = 1'b1;
               case (cmd_op_ff)
                  OP_ADD_FRONT: begin
                     if (full) rsp_status_in = STAT_FULL;
                     else begin
                        ctrl.act = ACT_SHIFT_UP;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_ADD_BACK: begin
                     if (full) rsp_status_in = STAT_FULL;
                     else begin
                        ctrl.act = ACT_WRITE;
                        ctrl.pos = count_ff[IDX_W-1:0];
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_TAKE_FRONT: begin
                     if (empty) rsp_status_in = STAT_EMPTY;
                     else begin
                        rsp_data_in = cell_data[0];
                        ctrl.act    = ACT_SHIFT_DOWN;
                        count_in    = count_ff - 1'b1;
                     end
                  end
                  OP_TAKE_BACK: begin
                     if (empty) rsp_status_in = STAT_EMPTY;
                     else begin
                        rsp_data_in = cell_data[count_ff[IDX_W-1:0] - 1'b1];
                        count_in    = count_ff - 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (cmd_index_ff >= count_ff) rsp_status_in = STAT_RANGE;
                     else rsp_data_in = cell_data[cmd_index_ff[IDX_W-1:0]];
                  end
                  OP_REPLACE: begin
                     if (cmd_index_ff >= count_ff) rsp_status_in = STAT_RANGE;
                     else begin
                        ctrl.act = ACT_WRITE;
                        ctrl.pos = cmd_index_ff[IDX_W-1:0];
                     end
                  end
                  OP_INSERT: begin
                     // range test takes priority over full
                     if (cmd_index_ff > count_ff) rsp_status_in = STAT_RANGE;
                     else if (full)               rsp_status_in = STAT_FULL;
                     else begin
                        ctrl.act = ACT_SHIFT_UP;
                        ctrl.pos = cmd_index_ff[IDX_W-1:0];
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (cmd_index_ff >= count_ff) rsp_status_in = STAT_RANGE;
                     else begin
                        ctrl.act = ACT_SHIFT_DOWN;
                        ctrl.pos = cmd_index_ff[IDX_W-1:0];
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_REMOVE_ALL: begin
                     emit        = 1'b0;
                     scan_pos_in = '0;
                     removed_in  = '0;
                  end
                  default: begin
                     rsp_status_in = STAT_OK;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (out_free) begin
                  emit           = 1'b1;
                  rsp_removed_in = removed_ff;
               end
            end else if (scan_match) begin
               // drop the match, stay on this position for the next entry
               ctrl.act   = ACT_SHIFT_DOWN;
               ctrl.pos   = scan_pos_ff[IDX_W-1:0];
               count_in   = count_ff - 1'b1;
               removed_in = removed_ff + 1'b1;
            end else begin
               scan_pos_in = scan_pos_ff + 1'b1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      rsp_count_in = count_in;
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_op_ff    <= cmd_op_in;
      cmd_data_ff  <= cmd_data_in;
      cmd_index_ff <= cmd_index_in;
      scan_pos_ff  <= scan_pos_in;
      removed_ff   <= removed_in;
      if (emit) begin
         rsp_data_ff    <= rsp_data_in;
         rsp_removed_ff <= rsp_removed_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_out      = rsp_data_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_count_after   = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

   // ---- checks ----
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   a_rsp_count_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_count_ff == count_ff)
      else $error("pending response count disagrees with list");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_pos_ff <= count_ff)
      else $error("scan position past end of list");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_EXEC)
      else $error("accepted command not executed");

endmodule

// ----- tb/idq_response_checker.sv -----
module idq_response_checker
   import idq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [3:0]                 req_opcode,
   input  logic signed [DATA_W-1:0]   req_data_in,
   input  logic [FIDX_W-1:0]          req_index,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [DATA_W-1:0]   rsp_data_out,
   input  logic [CNT_W-1:0]           rsp_removed_count,
   input  logic [CNT_W-1:0]           rsp_count_after,
   input  logic [1:0]                 rsp_status,
   output int                         outstanding,
   output int                         mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [DATA_W-1:0]   data_out;
      logic [CNT_W-1:0]           removed_count;
      logic [CNT_W-1:0]           count_after;
      status_type                 status;
   } outcome_type;

   // list contents in logical order, front first
   logic signed [DATA_W-1:0] list_entries[$];
   outcome_type              awaited_outcomes[$];

   function automatic outcome_type apply_command(input logic [3:0] opcode,
                                                 input logic signed [DATA_W-1:0] value,
                                                 input logic [FIDX_W-1:0] index);
      outcome_type              result;
      logic signed [DATA_W-1:0] survivors[$];
      int                       held;
      int                       pos;
      result = '0;
      result.status = STAT_OK;
      held = list_entries.size();
      pos = int'(index);
      case (opcode)
         OP_ADD_FRONT: begin
            if (held >= DEPTH) result.status = STAT_FULL;
            else list_entries.insert(0, value);
         end
         OP_ADD_BACK: begin
            if (held >= DEPTH) result.status = STAT_FULL;
            else list_entries.insert(held, value);
         end
         OP_TAKE_FRONT: begin
            if (held == 0) result.status = STAT_EMPTY;
            else begin
               result.data_out = list_entries[0];
               list_entries.delete(0);
            end
         end
         OP_TAKE_BACK: begin
            if (held == 0) result.status = STAT_EMPTY;
            else begin
               result.data_out = list_entries[held - 1];
               list_entries.delete(held - 1);
            end
         end
         OP_READ: begin
            if (pos >= held) result.status = STAT_RANGE;
            else result.data_out = list_entries[pos];
         end
         OP_REPLACE: begin
            if (pos >= held) result.status = STAT_RANGE;
            else list_entries[pos] = value;
         end
         OP_INSERT: begin
            // range test wins over full
            if (pos > held) result.status = STAT_RANGE;
            else if (held >= DEPTH) result.status = STAT_FULL;
            else list_entries.insert(pos, value);
         end
         OP_REMOVE: begin
            if (pos >= held) result.status = STAT_RANGE;
            else list_entries.delete(pos);
         end
         OP_REMOVE_ALL: begin
            foreach (list_entries[i])
               if (list_entries[i] != value)
                  survivors.insert(survivors.size(), list_entries[i]);
            result.removed_count = CNT_W'(held - survivors.size());
            list_entries = survivors;
         end
         default: ;
      endcase
      result.count_after = CNT_W'(list_entries.size());
      return result;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         list_entries.delete();
         awaited_outcomes.delete();
      end else begin
         if (req_valid && req_ready)
            awaited_outcomes.insert(awaited_outcomes.size(),
                                    apply_command(req_opcode, req_data_in, req_index));
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               $error("response with nothing outstanding: data_out %0d status %0d",
                      rsp_data_out, rsp_status);
               mismatches++;
            end else begin
               want = awaited_outcomes[0];
               awaited_outcomes.delete(0);
               if (rsp_data_out !== want.data_out) begin
                  $error("data_out: expected %0d, got %0d", want.data_out, rsp_data_out);
                  mismatches++;
               end
               if (rsp_removed_count !== want.removed_count) begin
                  $error("removed_count: expected %0d, got %0d",
                         want.removed_count, rsp_removed_count);
                  mismatches++;
               end
               if (rsp_count_after !== want.count_after) begin
                  $error("count_after: expected %0d, got %0d",
                         want.count_after, rsp_count_after);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
            end
         end
      end
      outstanding = awaited_outcomes.size();
   end

endmodule

// ----- tb/tb_indexed_double_ended_queue_top.sv -----
module tb_indexed_double_ended_queue_top;
   import idq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // opcodes the block does not decode; they must leave the list alone
   localparam logic [3:0] OP_SPARE_LO = 4'd9;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;

   localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int SQUEEZE_CYCLES  = 60;
   // worst case per transaction is roughly a long gap, a long stall and a
   // full remove all scan; 2100 of those is well under this
   localparam int CYCLE_LIMIT     = 1_000_000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [3:0]                 req_opcode;
   logic signed [DATA_W-1:0]   req_data_in;
   logic [FIDX_W-1:0]          req_index;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [DATA_W-1:0]   rsp_data_out;
   logic [CNT_W-1:0]           rsp_removed_count;
   logic [CNT_W-1:0]           rsp_count_after;
   logic [1:0]                 rsp_status;

   int outstanding;
   int mismatches;
   int accepted_total;
   int cycle_count;

   // idling styles, set per phase by the stimulus process
   bit sender_idles;
   bit receiver_stalls;
   // long receiver hold-offs: stimulus asks, receiver process serves
   int squeeze_asks;
   int squeeze_done;

   // small pool of values so remove all finds repeats
   logic signed [DATA_W-1:0] value_pool[6] =
      '{0, 1, -1, 7, MOST_NEGATIVE, MOST_POSITIVE};
   op_type growing_ops[3]   = '{OP_ADD_FRONT, OP_ADD_BACK, OP_INSERT};
   op_type shrinking_ops[4] = '{OP_TAKE_FRONT, OP_TAKE_BACK, OP_REMOVE, OP_REMOVE_ALL};
   op_type neutral_ops[2]   = '{OP_READ, OP_REPLACE};

   indexed_double_ended_queue_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_data_in       (req_data_in),
      .req_index         (req_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_out      (rsp_data_out),
      .rsp_removed_count (rsp_removed_count),
      .rsp_count_after   (rsp_count_after),
      .rsp_status        (rsp_status)
   );

   idq_response_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_data_in       (req_data_in),
      .req_index         (req_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_out      (rsp_data_out),
      .rsp_removed_count (rsp_removed_count),
      .rsp_count_after   (rsp_count_after),
      .rsp_status        (rsp_status),
      .outstanding       (outstanding),
      .mismatches        (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Request transactions seen at the rising edge; the sender polls this
   // count at the falling edge, so there is no race with req_ready.
   always @(posedge clock) begin
      if (reset) accepted_total <= 0;
      else if (req_valid && req_ready) accepted_total <= accepted_total + 1;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Mostly short idles, now and then a long one.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      else if (pick < 95) return $urandom_range(4, 8);
      else return $urandom_range(20, 40);
   endfunction

   // Receiver: every iteration starts and ends on a falling edge, so
   // rsp_ready gets one assignment per step.
   initial begin
      rsp_ready = 1'b0;
      squeeze_done = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (squeeze_asks != squeeze_done) begin
            // long hold-off: the block fills its output and stalls its input
            rsp_ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(negedge clock);
            squeeze_done++;
         end else if (receiver_stalls && $urandom_range(0, 99) < 30) begin
            rsp_ready <= 1'b0;
            repeat (idle_length()) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offer one command and hold it until it is taken. Called on a falling
   // edge; returns on a falling edge. Valid stays high when no gap follows.
   task automatic issue(input logic [3:0] opcode,
                        input logic signed [DATA_W-1:0] value,
                        input logic [FIDX_W-1:0] index);
      int taken_before;
      int gap;
      taken_before = accepted_total;
      req_valid   <= 1'b1;
      req_opcode  <= opcode;
      req_data_in <= value;
      req_index   <= index;
      do @(negedge clock); while (accepted_total == taken_before);
      gap = (sender_idles && $urandom_range(0, 1)) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Sender pause: nothing new goes in until every response is back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic random_command(input int grow_pct);
      int                       pick;
      logic [3:0]               opcode;
      logic signed [DATA_W-1:0] value;
      logic [FIDX_W-1:0]        index;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         opcode = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else if (pick < 23)
         opcode = neutral_ops[$urandom_range(0, 1)];
      else if ($urandom_range(0, 99) < grow_pct)
         opcode = growing_ops[$urandom_range(0, 2)];
      else
         opcode = shrinking_ops[$urandom_range(0, 3)];
      value = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 5)] : $urandom;
      // indices mostly near the legal range, sometimes anywhere in the field
      index = ($urandom_range(0, 99) < 85) ? FIDX_W'($urandom_range(0, DEPTH + 1))
                                           : FIDX_W'($urandom_range(0, 31));
      issue(opcode, value, index);
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_READ;
      req_data_in     = '0;
      req_index       = '0;
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      squeeze_asks    = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed: empty list corner cases ---
      issue(OP_TAKE_FRONT, 0, 0);
      issue(OP_TAKE_BACK, 0, 0);
      issue(OP_READ, 0, 0);
      issue(OP_REPLACE, 5, 0);
      issue(OP_REMOVE, 0, 0);
      issue(OP_INSERT, 3, 1);               // index past count
      issue(OP_REMOVE_ALL, 0, 0);           // ok even when empty
      // --- both ends, extremes of the data ---
      issue(OP_INSERT, MOST_NEGATIVE, 0);   // index equal to count: push back
      issue(OP_ADD_FRONT, MOST_POSITIVE, 0);
      issue(OP_ADD_BACK, -1, 0);
      issue(OP_ADD_FRONT, 0, 0);
      issue(OP_READ, 0, 3);
      issue(OP_READ, 0, 4);                 // one past the end
      issue(OP_READ, 0, 31);
      issue(OP_REPLACE, 32'sh5555_5555, 2);
      issue(OP_INSERT, -1, 4);
      issue(OP_INSERT, 32'shAAAA_AAAA, 1);
      issue(OP_REMOVE, 0, 0);
      issue(OP_REMOVE, 0, 4);
      issue(OP_REMOVE_ALL, -1, 0);
      issue(OP_TAKE_FRONT, 0, 0);
      issue(OP_TAKE_BACK, 0, 0);
      issue(OP_SPARE_LO, 1, 1);
      issue(OP_SPARE_HI, -1, 31);
      // --- fill to capacity, then the full cases ---
      while (accepted_total < 24 + DEPTH - 1)
         issue(OP_ADD_BACK, accepted_total[0] ? MOST_NEGATIVE : 7, 0);
      issue(OP_ADD_FRONT, 1, 0);
      issue(OP_ADD_BACK, 1, 0);
      issue(OP_INSERT, 1, FIDX_W'(DEPTH));          // good index, list full
      issue(OP_INSERT, 1, FIDX_W'(DEPTH + 1));      // bad index beats full
      issue(OP_READ, 0, FIDX_W'(DEPTH - 1));
      issue(OP_REMOVE, 0, FIDX_W'(DEPTH));
      issue(OP_REMOVE_ALL, MOST_NEGATIVE, 0);
      wait_drained();

      // --- random phases, alternating between filling and draining ---
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin sender_idles = 1'b0; receiver_stalls = 1'b0; end
            1:       begin sender_idles = 1'b1; receiver_stalls = 1'b0; end
            2:       begin sender_idles = 1'b0; receiver_stalls = 1'b1; end
            3:       begin sender_idles = 1'b0; receiver_stalls = 1'b1; end
            default: begin sender_idles = 1'b1; receiver_stalls = 1'b1; end
         endcase
         // one phase opens with the receiver held off while items keep coming
         if (phase == 3) squeeze_asks++;
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            random_command(phase[0] ? 35 : 65);
         wait_drained();
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (30) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
